FILE: src/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg: shared types and constants for the subnet match / MAC rewrite block
// Holds field widths, table and queue sizes, operation and status codes, and
// the command record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

  localparam int unsigned MAC_W     = 48;
  localparam int unsigned IP_W      = 32;
  localparam int unsigned PLEN_W    = 6;
  localparam int unsigned LOW_W     = 24;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_OUT   = 2'd2,
    OP_IN    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUTER_MAC = 2'd0,
    CFG_WAN_MAC    = 2'd1,
    CFG_IF_UP      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e              kind;
    logic             add_bad;
    logic [IP_W-1:0]  base;
    logic [IP_W-1:0]  mask;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic             ipv4;
  } cmd_t;

  // Top plen bits set; anything from 32 up saturates to a full mask.
  function automatic logic [IP_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [IP_W-1:0] m;
    if (plen >= PLEN_W'(IP_W)) begin
      m = '1;
    end else begin
      m = ~({IP_W{1'b1}} >> plen);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: src/smm_front.sv
// ----------------------------------------------------------------------------
// smm_front: request intake and classification
// Decodes the operation, flags invalid subnet adds, builds the prefix mask and
// pushes one command per accepted request into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_front (
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [smm_pkg::OP_W-1:0]   op_i,
  input  wire logic [smm_pkg::IP_W-1:0]   subnet_base_i,
  input  wire logic [smm_pkg::PLEN_W-1:0] prefix_length_i,
  input  wire logic [smm_pkg::IP_W-1:0]   packet_ip_i,
  input  wire logic [smm_pkg::MAC_W-1:0]  frame_mac_i,
  input  wire logic                       is_ipv4_i,
  input  wire logic                       q_full_i,
  output logic                            push_valid_o,
  output smm_pkg::cmd_t                   push_cmd_o
);
  import smm_pkg::*;

  assign in_ready_o   = ~q_full_i;
  assign push_valid_o = in_valid_i & ~q_full_i;

  always_comb begin
    push_cmd_o         = '0;
    push_cmd_o.kind    = op_e'(op_i);
    push_cmd_o.add_bad = (subnet_base_i == '0) || (prefix_length_i == '0);
    push_cmd_o.mask    = prefix_mask(prefix_length_i);
    // store the base already masked so a lookup is one AND and compare
    push_cmd_o.base    = subnet_base_i & prefix_mask(prefix_length_i);
    push_cmd_o.ip      = packet_ip_i;
    push_cmd_o.mac     = frame_mac_i;
    push_cmd_o.ipv4    = is_ipv4_i;
  end

endmodule

`default_nettype wire

FILE: src/smm_queue.sv
// ----------------------------------------------------------------------------
// smm_queue: short command queue
// Decouples the intake from the table back end so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire smm_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output smm_pkg::cmd_t      cmd_o
);
  import smm_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/smm_back.sv
// ----------------------------------------------------------------------------
// smm_back: subnet table and rewrite back end
// Holds the configuration and the subnet cells, executes adds and clears,
// compares frame IPs against all cells in parallel and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [smm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [smm_pkg::MAC_W-1:0]     cfg_data_i,
  input  wire logic                          q_valid_i,
  input  wire smm_pkg::cmd_t                 q_cmd_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [smm_pkg::MAC_W-1:0]          result_mac_o,
  output logic                               rewritten_o,
  output logic [smm_pkg::STATUS_W-1:0]       status_o
);
  import smm_pkg::*;

  // configuration
  logic [MAC_W-1:0] router_mac_q, wan_mac_q;
  logic             if_up_q;

  // subnet cells
  logic [IP_W-1:0]  base_q [TABLE_ENTRIES];
  logic [IP_W-1:0]  mask_q [TABLE_ENTRIES];
  logic [CNT_W-1:0] entry_count_q, entry_count_d;

  // lookup stage
  logic                     s1_valid_q;
  op_e                      s1_kind_q;
  logic [MAC_W-1:0]         s1_mac_q;
  logic                     s1_elig_q;
  logic [TABLE_ENTRIES-1:0] s1_hit_q;
  status_e                  s1_status_q;
  logic [TABLE_ENTRIES-1:0] hit_d;
  status_e                  status_d;
  logic                     elig_d;
  logic                     tbl_wr;

  // result register
  logic             out_valid_q;
  logic [MAC_W-1:0] out_mac_q, out_mac_d;
  logic             out_rew_q, out_rew_d;
  status_e          out_status_q;

  logic out_load, s1_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      router_mac_q <= '0;
      wan_mac_q    <= '0;
      if_up_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROUTER_MAC: router_mac_q <= cfg_data_i;
        CFG_WAN_MAC:    wan_mac_q    <= cfg_data_i;
        CFG_IF_UP:      if_up_q      <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  assign out_load = s1_valid_q & (~out_valid_q | out_ready_i);
  assign s1_free  = ~s1_valid_q | out_load;
  assign q_pop_o  = q_valid_i & s1_free;

  // add / clear bookkeeping
  always_comb begin
    entry_count_d = entry_count_q;
    status_d      = ST_OK;
    tbl_wr        = 1'b0;
    case (q_cmd_i.kind)
      OP_ADD: begin
        if (q_cmd_i.add_bad) begin
          status_d = ST_INVALID;
        end else if (entry_count_q >= CNT_W'(TABLE_ENTRIES)) begin
          status_d = ST_FULL;
        end else begin
          tbl_wr        = q_pop_o;
          entry_count_d = entry_count_q + CNT_W'(1);
        end
      end
      OP_CLEAR: entry_count_d = '0;
      OP_OUT, OP_IN: ;
      default: ;
    endcase
  end

  always_comb begin
    elig_d = 1'b0;
    case (q_cmd_i.kind)
      OP_OUT:  elig_d = if_up_q & q_cmd_i.ipv4 & (q_cmd_i.mac == router_mac_q);
      OP_IN:   elig_d = if_up_q & q_cmd_i.ipv4 & (q_cmd_i.mac == wan_mac_q);
      default: elig_d = 1'b0;
    endcase
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (tbl_wr && (entry_count_q == CNT_W'(k))) begin
        base_q[k] <= q_cmd_i.base;
        mask_q[k] <= q_cmd_i.mask;
      end
    end
    assign hit_d[k] = (CNT_W'(k) < entry_count_q) &&
                      ((q_cmd_i.ip & mask_q[k]) == base_q[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      s1_valid_q    <= 1'b0;
    end else begin
      if (q_pop_o) begin
        entry_count_q <= entry_count_d;
      end
      if (s1_free) begin
        s1_valid_q <= q_pop_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_kind_q   <= q_cmd_i.kind;
      s1_mac_q    <= q_cmd_i.mac;
      s1_elig_q   <= elig_d;
      s1_hit_q    <= hit_d;
      s1_status_q <= status_d;
    end
  end

  // rewrite the low bytes with the other interface's MAC
  always_comb begin
    out_rew_d = s1_elig_q & (|s1_hit_q);
    out_mac_d = '0;
    case (s1_kind_q)
      OP_OUT: out_mac_d = out_rew_d ? {s1_mac_q[MAC_W-1:LOW_W], wan_mac_q[LOW_W-1:0]}
                                    : s1_mac_q;
      OP_IN:  out_mac_d = out_rew_d ? {s1_mac_q[MAC_W-1:LOW_W], router_mac_q[LOW_W-1:0]}
                                    : s1_mac_q;
      default: out_mac_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mac_q    <= out_mac_d;
      out_rew_q    <= out_rew_d;
      out_status_q <= s1_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_mac_o = out_mac_q;
  assign rewritten_o  = out_rew_q;
  assign status_o     = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_cmd_i.kind == OP_CLEAR) |=> (entry_count_q == '0))
    else $error("clear did not empty the table");

  a_rew_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rew_q) |-> (out_status_q == ST_OK))
    else $error("rewrite reported with non-ok status");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_load) |=> s1_valid_q)
    else $error("lookup stage dropped a request");

endmodule

`default_nettype wire

FILE: src/subnet_match_mac_rewrite.sv
// Throughput: one request per cycle while the output is not stalled; set by
// the two-entry command queue and the two-stage back end (parallel cell
// compare, then result register).
// Reset: clears queue, pipeline valids, entry count and all configuration
// registers to zero; subnet cells hold no reset value and are read only below
// the entry count.
// ----------------------------------------------------------------------------
// subnet_match_mac_rewrite: IPv4 subnet table with frame MAC rewrite
// Front end classifies requests into a short queue; the back end maintains
// the subnet table and rewrites matching outgoing and incoming frame MACs.
// ----------------------------------------------------------------------------
`default_nettype none

module subnet_match_mac_rewrite (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [smm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [smm_pkg::MAC_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [smm_pkg::OP_W-1:0]      op_i,
  input  wire logic [smm_pkg::IP_W-1:0]      subnet_base_i,
  input  wire logic [smm_pkg::PLEN_W-1:0]    prefix_length_i,
  input  wire logic [smm_pkg::IP_W-1:0]      packet_ip_i,
  input  wire logic [smm_pkg::MAC_W-1:0]     frame_mac_i,
  input  wire logic                          is_ipv4_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [smm_pkg::MAC_W-1:0]          result_mac_o,
  output logic                               rewritten_o,
  output logic [smm_pkg::STATUS_W-1:0]       status_o
);
  import smm_pkg::*;

  logic push_valid, q_full, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;

  smm_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .subnet_base_i   (subnet_base_i),
    .prefix_length_i (prefix_length_i),
    .packet_ip_i     (packet_ip_i),
    .frame_mac_i     (frame_mac_i),
    .is_ipv4_i       (is_ipv4_i),
    .q_full_i        (q_full),
    .push_valid_o    (push_valid),
    .push_cmd_o      (push_cmd)
  );

  smm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  smm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_mac_o (result_mac_o),
    .rewritten_o  (rewritten_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

FILE: test/tb_subnet_match_mac_rewrite.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_subnet_match_mac_rewrite: self-checking bench for the subnet MAC rewrite
// Walks a short table of directed requests, then random add / clear / frame
// sequences under several MAC and link settings. Every result is checked
// against the row's expected verdict or an in-bench model of the subnet
// table, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------

module tb_subnet_match_mac_rewrite;
  import smm_pkg::*;

  localparam int DIRECTED_ROWS  = 25;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 258;
  localparam int CALM_PHASE     = 2;
  localparam int BACKLOG_PHASE  = 3;
  localparam int BACKLOG_CYCLES = 400;
  localparam int IDLE_PCT       = 38;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [MAC_W-1:0] ROUTER_A = 48'h02_00_00_AA_BB_CC;
  localparam logic [MAC_W-1:0] WAN_A    = 48'h06_11_22_33_44_55;
  localparam logic [MAC_W-1:0] MAC_ALL  = '1;

  typedef struct packed {
    logic [MAC_W-1:0] result_mac;
    logic             rewritten;
    status_e          status;
  } verdict_t;

  typedef struct packed {
    logic [MAC_W-1:0] router;
    logic [MAC_W-1:0] wan;
    logic             up;
  } link_cfg_t;

  typedef struct packed {
    logic [1:0]        phase;
    op_e               op;
    logic [IP_W-1:0]   base;
    logic [PLEN_W-1:0] plen;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic              v4;
    logic [4:0]        reps;
    logic              fixed_exp;
    verdict_t          exp;
  } probe_row_t;

  localparam verdict_t V_OK      = '{48'h0, 1'b0, ST_OK};
  localparam verdict_t V_INVALID = '{48'h0, 1'b0, ST_INVALID};
  localparam verdict_t V_FULL    = '{48'h0, 1'b0, ST_FULL};
  localparam verdict_t V_PASS_R  = '{ROUTER_A, 1'b0, ST_OK};
  localparam verdict_t V_PASS_W  = '{WAN_A, 1'b0, ST_OK};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [MAC_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OP_W-1:0]      op_i;
  logic [IP_W-1:0]      subnet_base_i;
  logic [PLEN_W-1:0]    prefix_length_i;
  logic [IP_W-1:0]      packet_ip_i;
  logic [MAC_W-1:0]     frame_mac_i;
  logic                 is_ipv4_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [MAC_W-1:0]     result_mac_o;
  logic                 rewritten_o;
  logic [STATUS_W-1:0]  status_o;

  subnet_match_mac_rewrite dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .subnet_base_i   (subnet_base_i),
    .prefix_length_i (prefix_length_i),
    .packet_ip_i     (packet_ip_i),
    .frame_mac_i     (frame_mac_i),
    .is_ipv4_i       (is_ipv4_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_mac_o    (result_mac_o),
    .rewritten_o     (rewritten_o),
    .status_o        (status_o)
  );

  // Shadow of the subnet table and the link settings
  logic [IP_W-1:0]  tbl_base [TABLE_ENTRIES];
  logic [IP_W-1:0]  tbl_mask [TABLE_ENTRIES];
  int               tbl_used = 0;
  logic [MAC_W-1:0] sh_router_mac = '0;
  logic [MAC_W-1:0] sh_wan_mac = '0;
  logic             sh_if_up = 1'b0;

  verdict_t   verdict_q [$];
  probe_row_t probe_rows [DIRECTED_ROWS];
  link_cfg_t  probe_cfgs [3];
  link_cfg_t  mix_cfgs [RANDOM_PHASES];

  int   requests_sent = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;
  logic calm = 1'b0;
  logic backlog_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MAC_W-1:0];
  endfunction

  // plen ones from bit 31 down for plen 1 to 31; zero and anything from 32 up give a full mask
  function automatic logic [IP_W-1:0] subnet_mask(input logic [PLEN_W-1:0] plen);
    logic signed [IP_W-1:0] top;
    top = 32'sh8000_0000;
    if (plen >= 6'd32) return '1;
    return top >>> (plen - 6'd1);
  endfunction

  function automatic verdict_t predict_verdict(input op_e op, input logic [IP_W-1:0] base,
                                               input logic [PLEN_W-1:0] plen,
                                               input logic [IP_W-1:0] ip,
                                               input logic [MAC_W-1:0] mac, input logic v4);
    verdict_t         v;
    logic [MAC_W-1:0] own;
    logic [MAC_W-1:0] donor;
    logic             hit;
    v = V_OK;
    case (op)
      OP_ADD: begin
        if (base == '0 || plen == '0) begin
          v.status = ST_INVALID;
        end else if (tbl_used == int'(TABLE_ENTRIES)) begin
          v.status = ST_FULL;
        end else begin
          tbl_base[tbl_used] = base;
          tbl_mask[tbl_used] = subnet_mask(plen);
          tbl_used++;
        end
      end
      OP_CLEAR: tbl_used = 0;
      default: begin
        own   = (op == OP_OUT) ? sh_router_mac : sh_wan_mac;
        donor = (op == OP_OUT) ? sh_wan_mac : sh_router_mac;
        hit   = 1'b0;
        for (int k = 0; k < tbl_used; k++) begin
          if (((ip ^ tbl_base[k]) & tbl_mask[k]) == '0) hit = 1'b1;
        end
        v.result_mac = mac;
        if (sh_if_up && v4 && mac == own && hit) begin
          v.result_mac = {mac[MAC_W-1:LOW_W], donor[LOW_W-1:0]};
          v.rewritten  = 1'b1;
        end
      end
    endcase
    return v;
  endfunction

  // Enter at a clock edge; return at the edge where the request is taken.
  task automatic issue_request(input op_e op, input logic [IP_W-1:0] base,
                               input logic [PLEN_W-1:0] plen, input logic [IP_W-1:0] ip,
                               input logic [MAC_W-1:0] mac, input logic v4,
                               input logic fixed_exp, input verdict_t exp);
    verdict_t want;
    want = predict_verdict(op, base, plen, ip, mac, v4);
    if (fixed_exp) want = exp;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    subnet_base_i   <= base;
    prefix_length_i <= plen;
    packet_ip_i     <= ip;
    frame_mac_i     <= mac;
    is_ipv4_i       <= v4;
    do @(posedge clk_i); while (!in_ready_o);
    verdict_q.push_back(want);
    requests_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [MAC_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROUTER_MAC: sh_router_mac = data;
      CFG_WAN_MAC:    sh_wan_mac = data;
      default:        sh_if_up = data[0];
    endcase
  endtask

  // Drain all results, let the pipe settle, then rewrite every register
  task automatic apply_settings(input link_cfg_t s);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_ROUTER_MAC, s.router);
    write_reg(CFG_WAN_MAC, s.wan);
    write_reg(CFG_IF_UP, {47'b0, s.up});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic note_mismatch(input string field, input logic [MAC_W-1:0] want,
                               input logic [MAC_W-1:0] got);
    $display("%0t mismatch on %s: expected %h, actual %h", $time, field, want, got);
    mismatches++;
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (backlog_req) begin
        backlog_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        note_mismatch("unexpected result mac", '0, result_mac_o);
      end else begin
        want = verdict_q.pop_front();
        if (result_mac_o !== want.result_mac)
          note_mismatch("result_mac", want.result_mac, result_mac_o);
        if (rewritten_o !== want.rewritten)
          note_mismatch("rewritten", 48'(want.rewritten), 48'(rewritten_o));
        if (status_o !== want.status)
          note_mismatch("status", 48'(want.status), 48'(status_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [1:0]        cur_phase;
    int                pick;
    int                n;
    int                k;
    int                phase_end;
    op_e               fop;
    logic [IP_W-1:0]   base;
    logic [IP_W-1:0]   ip;
    logic [PLEN_W-1:0] plen;
    logic [MAC_W-1:0]  mac;
    logic [MAC_W-1:0]  own;
    logic [MAC_W-1:0]  donor;

    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_ROUTER_MAC;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    op_i            <= OP_ADD;
    subnet_base_i   <= '0;
    prefix_length_i <= '0;
    packet_ip_i     <= '0;
    frame_mac_i     <= '0;
    is_ipv4_i       <= 1'b0;

    probe_cfgs[0] = '{48'h0, 48'h0, 1'b0};
    probe_cfgs[1] = '{ROUTER_A, WAN_A, 1'b1};
    probe_cfgs[2] = '{ROUTER_A, WAN_A, 1'b0};

    // phase, op, base, plen, ip, mac, ipv4, repeat, typed, expected
    // reset settings: links down, nothing may be rewritten
    probe_rows[0]  = '{2'd0, OP_OUT, 32'h0, 6'd0, 32'h0A00_0001, 48'h0, 1'b1, 5'd1, 1'b1, V_OK};
    probe_rows[1]  = '{2'd0, OP_ADD, 32'h0A00_0000, 6'd8, 32'h0, 48'h0, 1'b0, 5'd1, 1'b1, V_OK};
    probe_rows[2]  = '{2'd0, OP_IN, 32'h0, 6'd0, 32'h0A00_0001, 48'h0, 1'b1, 5'd1, 1'b1, V_OK};
    // zero base or zero prefix is refused
    probe_rows[3]  = '{2'd1, OP_ADD, 32'h0, 6'd8, 32'h0, 48'h0, 1'b0, 5'd1, 1'b1, V_INVALID};
    probe_rows[4]  = '{2'd1, OP_ADD, 32'hC0A8_0100, 6'd0, 32'h0, 48'h0, 1'b0, 5'd1, 1'b1,
                       V_INVALID};
    probe_rows[5]  = '{2'd1, OP_ADD, 32'hC0A8_0100, 6'd24, 32'h0, 48'h0, 1'b0, 5'd1, 1'b1, V_OK};
    probe_rows[6]  = '{2'd1, OP_ADD, 32'hFFFF_FFFF, 6'd63, 32'h0, 48'h0, 1'b0, 5'd1, 1'b1, V_OK};
    probe_rows[7]  = '{2'd1, OP_ADD, 32'h8000_0000, 6'd1, 32'h0, 48'h0, 1'b0, 5'd1, 1'b1, V_OK};
    probe_rows[8]  = '{2'd1, OP_OUT, 32'h0, 6'd0, 32'h0A7F_0001, ROUTER_A, 1'b1, 5'd1, 1'b0, V_OK};
    probe_rows[9]  = '{2'd1, OP_OUT, 32'h0, 6'd0, 32'h0A7F_0001, ROUTER_A, 1'b0, 5'd1, 1'b1,
                       V_PASS_R};
    probe_rows[10] = '{2'd1, OP_OUT, 32'h0, 6'd0, 32'h0A7F_0001, ROUTER_A ^ 48'h1, 1'b1, 5'd1,
                       1'b0, V_OK};
    probe_rows[11] = '{2'd1, OP_IN, 32'h0, 6'd0, 32'hC0A8_014D, WAN_A, 1'b1, 5'd1, 1'b0, V_OK};
    probe_rows[12] = '{2'd1, OP_IN, 32'h0, 6'd0, 32'hFFFF_FFFF, WAN_A, 1'b1, 5'd1, 1'b0, V_OK};
    probe_rows[13] = '{2'd1, OP_IN, 32'h0, 6'd0, 32'h0000_0001, WAN_A, 1'b1, 5'd1, 1'b0, V_OK};
    probe_rows[14] = '{2'd1, OP_OUT, 32'h0, 6'd0, 32'hC0A8_0201, ROUTER_A, 1'b1, 5'd1, 1'b0, V_OK};
    probe_rows[15] = '{2'd1, OP_IN, 32'h0, 6'd0, 32'h0A00_0000, MAC_ALL, 1'b1, 5'd1, 1'b0, V_OK};
    probe_rows[16] = '{2'd1, OP_CLEAR, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, MAC_ALL, 1'b1, 5'd1,
                       1'b1, V_OK};
    probe_rows[17] = '{2'd1, OP_OUT, 32'h0, 6'd0, 32'h0A00_0001, ROUTER_A, 1'b1, 5'd1, 1'b0, V_OK};
    // fill the table, then overflow it; a bad add still reports invalid first
    probe_rows[18] = '{2'd1, OP_ADD, 32'hAC10_0000, 6'd12, 32'h0, 48'h0, 1'b0, 5'd16, 1'b0, V_OK};
    probe_rows[19] = '{2'd1, OP_ADD, 32'h0A00_0000, 6'd8, 32'h0, 48'h0, 1'b0, 5'd1, 1'b1, V_FULL};
    probe_rows[20] = '{2'd1, OP_ADD, 32'h0, 6'd8, 32'h0, 48'h0, 1'b0, 5'd1, 1'b1, V_INVALID};
    probe_rows[21] = '{2'd1, OP_IN, 32'h0, 6'd0, 32'hAC1F_FFFF, WAN_A, 1'b1, 5'd1, 1'b0, V_OK};
    // links down: matching frames pass untouched
    probe_rows[22] = '{2'd2, OP_OUT, 32'h0, 6'd0, 32'hAC10_0001, ROUTER_A, 1'b1, 5'd1, 1'b1,
                       V_PASS_R};
    probe_rows[23] = '{2'd2, OP_IN, 32'h0, 6'd0, 32'hAC10_0001, WAN_A, 1'b1, 5'd1, 1'b1, V_PASS_W};
    probe_rows[24] = '{2'd2, OP_CLEAR, 32'h0, 6'd0, 32'h0, 48'h0, 1'b0, 5'd1, 1'b1, V_OK};

    mix_cfgs[0] = '{rand_mac(), rand_mac(), 1'b1};
    mix_cfgs[1] = '{48'h0, MAC_ALL, 1'b1};
    mix_cfgs[2] = '{MAC_ALL, 48'h0, 1'b1};
    mac = rand_mac();
    mix_cfgs[3] = '{mac, mac, 1'b1};
    mix_cfgs[4] = '{rand_mac(), rand_mac(), 1'b0};
    mix_cfgs[5] = '{rand_mac(), rand_mac(), 1'b1};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_phase = 2'd0;
    foreach (probe_rows[i]) begin
      if (probe_rows[i].phase != cur_phase) begin
        cur_phase = probe_rows[i].phase;
        apply_settings(probe_cfgs[cur_phase]);
      end
      repeat (probe_rows[i].reps)
        issue_request(probe_rows[i].op, probe_rows[i].base, probe_rows[i].plen,
                      probe_rows[i].ip, probe_rows[i].mac, probe_rows[i].v4,
                      probe_rows[i].fixed_exp, probe_rows[i].exp);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(mix_cfgs[p]);
      calm = (p == CALM_PHASE);
      if (p == BACKLOG_PHASE) backlog_req = 1'b1;
      phase_end = requests_sent + PHASE_ITEMS;
      while (requests_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          // noise: any op, any field value
          issue_request(op_e'($urandom_range(3)), $urandom, 6'($urandom_range(63)), $urandom,
                        rand_mac(), 1'($urandom), 1'b0, V_OK);
        end else if (pick < 25) begin
          issue_request(OP_CLEAR, $urandom, 6'($urandom_range(63)), $urandom, rand_mac(),
                        1'($urandom), 1'b0, V_OK);
        end else if (pick < 55) begin
          n = ($urandom_range(99) < 20) ? $urandom_range(8, 20) : $urandom_range(1, 6);
          repeat (n) begin
            base = ($urandom_range(9) == 0) ? 32'h0 : $urandom;
            k = $urandom_range(99);
            if (k < 8) plen = 6'd0;
            else if (k < 16) plen = 6'($urandom_range(33, 63));
            else plen = 6'($urandom_range(1, 32));
            issue_request(OP_ADD, base, plen, $urandom, rand_mac(), 1'($urandom), 1'b0, V_OK);
          end
        end else begin
          // frames aimed at listed subnets and the interface MACs
          n = $urandom_range(1, 8);
          repeat (n) begin
            fop   = $urandom_range(1) ? OP_OUT : OP_IN;
            own   = (fop == OP_OUT) ? sh_router_mac : sh_wan_mac;
            donor = (fop == OP_OUT) ? sh_wan_mac : sh_router_mac;
            if (tbl_used > 0 && $urandom_range(99) < 80) begin
              k  = $urandom_range(tbl_used - 1);
              ip = (tbl_base[k] & tbl_mask[k]) | ($urandom & ~tbl_mask[k]);
            end else begin
              ip = $urandom;
            end
            pick = $urandom_range(99);
            if (pick < 70) mac = own;
            else if (pick < 80) mac = donor;
            else if (pick < 90) mac = own ^ (48'h1 << $urandom_range(47));
            else mac = rand_mac();
            issue_request(fop, $urandom, 6'($urandom_range(63)), ip, mac,
                          $urandom_range(99) < 85, 1'b0, V_OK);
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/smm_pkg.sv
src/smm_front.sv
src/smm_queue.sv
src/smm_back.sv
src/subnet_match_mac_rewrite.sv
test/tb_subnet_match_mac_rewrite.sv
